/* sv/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// lfs_pkg: shared definitions for the Fibonacci-like subsequence block
// Field widths, length constants and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package lfs_pkg;

   localparam int MAX_ITEMS_DEFAULT = 128;
   localparam int VALUE_W           = 31;
   localparam int LEN_W             = 8;

   localparam logic [LEN_W-1:0] LEN_MAX  = 8'd255;
   localparam logic [LEN_W-1:0] LEN_BASE = 8'd2;

   // controller -> datapath, at most one work command per cycle
   typedef struct packed {
      logic clear_step;   // invalidate one lookup slot during the reset pass
      logic take;         // accept the input word
      logic ins_step;     // one insert probe of the lookup table
      logic diff;         // form difference for the current earlier position
      logic lookup;       // one search probe of the lookup table
      logic write;        // write the pair entry, update best, step down
      logic flush_start;  // rewind the used-slot list
      logic flush_step;   // invalidate one used slot
      logic emit;         // load the result word, clear the counters
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;   // reset pass covered every slot
      logic full;         // store holds the maximum number of values
      logic slot_done;    // probe hit or reached an empty slot
      logic j_zero;       // new value sits at position zero
      logic diff_neg;     // difference below zero, no match possible
      logic i_zero;       // last earlier position handled
      logic last;         // current word closes the sequence
      logic flush_done;   // every used slot invalidated
      logic rsp_free;     // result register can take a new word
   } sts_type;

endpackage

/* sv/lfs_ctrl.sv */
// ----------------------------------------------------------------------------
// lfs_ctrl: sequencer for the Fibonacci-like subsequence block
// Walks the reset clearing pass, the insert probe, the loop over earlier
// positions, the flush of used lookup slots and the result hand-off.
// ----------------------------------------------------------------------------
module lfs_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lfs_pkg::sts_type sts,
   output lfs_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_INS   = 9'b000000100,
      S_DIFF  = 9'b000001000,
      S_LOOK  = 9'b000010000,
      S_WRITE = 9'b000100000,
      S_DONE  = 9'b001000000,
      S_FLUSH = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // take words only when idle
   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clear_step = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = sts.full ? S_DONE : S_INS;
            end
         end
         S_INS: begin
            cmd.ins_step = 1'b1;
            if (sts.slot_done) begin
               state_in = sts.j_zero ? S_DONE : S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = sts.diff_neg ? S_WRITE : S_LOOK;
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            if (sts.slot_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = sts.i_zero ? S_DONE : S_DIFF;
         end
         S_DONE: begin
            if (sts.last) begin
               cmd.flush_start = 1'b1;
               state_in        = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.flush_done) begin
               state_in = S_EMIT;
            end else begin
               cmd.flush_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/lfs_dpath.sv */
// ----------------------------------------------------------------------------
// lfs_dpath: storage and arithmetic for the Fibonacci-like subsequence block
// Value store, pair-length table, hashed value-to-position lookup table with
// a used-slot list, running best length and the result register.
// ----------------------------------------------------------------------------
module lfs_dpath #(
   parameter int MAX_ITEMS = lfs_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lfs_pkg::cmd_type               cmd,
   output lfs_pkg::sts_type               sts,
   input  logic [lfs_pkg::VALUE_W-1:0]    req_value,
   input  logic                           req_last,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [lfs_pkg::LEN_W-1:0]      rsp_best_length,
   output logic                           rsp_overflow
);

   localparam int IW    = $clog2(MAX_ITEMS);
   localparam int CW    = $clog2(MAX_ITEMS + 1);
   localparam int HB    = IW + 1;
   localparam int SW    = HB + 1;
   localparam int DEPTH = 2 ** IW;
   localparam int SLOTS = 2 ** HB;
   localparam int VW    = lfs_pkg::VALUE_W;
   localparam int LW    = lfs_pkg::LEN_W;

   typedef struct packed {
      logic          valid;
      logic [VW-1:0] value;
      logic [IW-1:0] index;
   } slot_type;

   // fold the value onto the slot index
   function automatic logic [HB-1:0] slot_hash(input logic [VW-1:0] x);
      logic [HB-1:0] h;
      h = '0;
      for (int b = 0; b < VW; b++) begin
         h[b % HB] = h[b % HB] ^ x[b];
      end
      return h;
   endfunction

   // memories
   logic [VW-1:0] value_mem [DEPTH];
   logic [LW-1:0] pair_mem  [DEPTH*DEPTH];
   slot_type      slot_mem  [SLOTS];
   logic [HB-1:0] used_mem  [DEPTH];

   // control registers
   logic [CW-1:0] count_ff;
   logic [CW-1:0] used_count_ff;
   logic [SW-1:0] sweep_ff;
   logic [SW-1:0] sweep_in;
   logic [LW-1:0] best_ff;
   logic          ovf_ff;
   logic          rsp_valid_ff;

   // payload registers
   logic [IW-1:0] j_ff;
   logic [IW-1:0] i_ff;
   logic [IW-1:0] i_in;
   logic [HB-1:0] probe_ff;
   logic [HB-1:0] probe_in;
   logic [VW-1:0] v_ff;
   logic [VW-1:0] target_ff;
   logic          last_ff;
   logic          use_dp_ff;
   slot_type      slot_rd_ff;
   logic [VW-1:0] a_rd_ff;
   logic [LW-1:0] pair_rd_ff;
   logic [HB-1:0] used_rd_ff;
   logic [LW-1:0] rsp_len_ff;
   logic          rsp_ovf_ff;

   // combinational terms
   logic [VW:0]   diff;
   logic          slot_hit;
   logic          slot_done;
   logic          k_lt_i;
   logic [LW-1:0] len_inc;
   logic [LW-1:0] len;
   logic          full;
   logic          slot_we;
   logic [HB-1:0] slot_waddr;
   slot_type      slot_wdata;

   assign diff      = {1'b0, v_ff} - {1'b0, a_rd_ff};
   assign slot_hit  = slot_rd_ff.valid && (slot_rd_ff.value == target_ff);
   assign slot_done = !slot_rd_ff.valid || slot_hit;
   assign k_lt_i    = (slot_rd_ff.index < i_ff);
   assign len_inc   = (pair_rd_ff == lfs_pkg::LEN_MAX) ? lfs_pkg::LEN_MAX
                                                      : pair_rd_ff + 1'b1;
   assign len       = use_dp_ff ? len_inc : lfs_pkg::LEN_BASE;
   assign full      = (count_ff == CW'(MAX_ITEMS));

   // steer the next probe slot
   always_comb begin
      priority if (cmd.take) begin
         probe_in = slot_hash(req_value);
      end else if (cmd.diff) begin
         probe_in = slot_hash(diff[VW-1:0]);
      end else if ((cmd.ins_step || cmd.lookup) && !slot_done) begin
         probe_in = probe_ff + 1'b1;
      end else begin
         probe_in = probe_ff;
      end
   end

   // step the earlier position down from j-1
   always_comb begin
      priority if (cmd.ins_step && slot_done) begin
         i_in = j_ff - 1'b1;
      end else if (cmd.write) begin
         i_in = i_ff - 1'b1;
      end else begin
         i_in = i_ff;
      end
   end

   // sweep pointer: reset pass over all slots, flush pass over the used list
   always_comb begin
      priority if (cmd.flush_start) begin
         sweep_in = '0;
      end else if (cmd.clear_step || cmd.flush_step) begin
         sweep_in = sweep_ff + 1'b1;
      end else begin
         sweep_in = sweep_ff;
      end
   end

   // single write port of the lookup table
   always_comb begin
      slot_we    = 1'b0;
      slot_waddr = probe_ff;
      slot_wdata = '0;
      priority if (cmd.clear_step) begin
         slot_we    = 1'b1;
         slot_waddr = sweep_ff[HB-1:0];
      end else if (cmd.flush_step) begin
         slot_we    = 1'b1;
         slot_waddr = used_rd_ff;
      end else if (cmd.ins_step && slot_done) begin
         slot_we          = 1'b1;
         slot_wdata.valid = 1'b1;
         slot_wdata.value = v_ff;
         slot_wdata.index = j_ff;
      end else begin
         slot_we = 1'b0;
      end
   end

   // counters, best length and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         used_count_ff <= '0;
         sweep_ff      <= '0;
         best_ff       <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         if (cmd.take) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.ins_step && !slot_rd_ff.valid) begin
            used_count_ff <= used_count_ff + 1'b1;
         end
         if (cmd.write && (len > best_ff)) begin
            best_ff <= len;
         end
         if (cmd.emit) begin
            count_ff      <= '0;
            used_count_ff <= '0;
            best_ff       <= '0;
            ovf_ff        <= 1'b0;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // memory reads, registered every cycle
   always_ff @(posedge clock) begin
      probe_ff   <= probe_in;
      i_ff       <= i_in;
      slot_rd_ff <= slot_mem[probe_in];
      a_rd_ff    <= value_mem[i_in];
      used_rd_ff <= used_mem[sweep_in[IW-1:0]];
      pair_rd_ff <= pair_mem[{slot_rd_ff.index, i_ff}];
   end

   // memory writes and item registers
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (cmd.take) begin
         last_ff   <= req_last;
         target_ff <= req_value;
         if (!full) begin
            v_ff                         <= req_value;
            j_ff                         <= count_ff[IW-1:0];
            value_mem[count_ff[IW-1:0]]  <= req_value;
         end
      end
      if (cmd.ins_step && !slot_rd_ff.valid) begin
         used_mem[used_count_ff[IW-1:0]] <= probe_ff;
      end
      if (cmd.diff) begin
         target_ff <= diff[VW-1:0];
         use_dp_ff <= 1'b0;
      end
      if (cmd.lookup && slot_done) begin
         use_dp_ff <= slot_hit && k_lt_i;
      end
      if (cmd.write) begin
         pair_mem[{i_ff, j_ff}] <= len;
      end
      if (cmd.emit) begin
         rsp_len_ff <= (best_ff > lfs_pkg::LEN_BASE) ? best_ff : '0;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   // status to the controller
   assign sts.clear_done = sweep_ff[HB];
   assign sts.full       = full;
   assign sts.slot_done  = slot_done;
   assign sts.j_zero     = (j_ff == '0);
   assign sts.diff_neg   = diff[VW];
   assign sts.i_zero     = (i_ff == '0);
   assign sts.last       = last_ff;
   assign sts.flush_done = (sweep_ff >= SW'(used_count_ff));
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_len_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

/* sv/longest_fibonacci_subsequence.sv */
// ----------------------------------------------------------------------------
// longest_fibonacci_subsequence: longest Fibonacci-like run over a stream
// Stores one value per request word, up to MAX_ITEMS, and keeps a pair-length
// table; the word marked last returns the best length of the sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall): req_value, req_last. A word is
//   taken when req_valid is high and req_stall is low. Result channel
//   (rsp_valid/rsp_stall): rsp_best_length, rsp_overflow, one word for each
//   request word marked last; a best length of two or less reads as 0.
//   Words past MAX_ITEMS in one sequence are dropped and set rsp_overflow.
// Operation:
//   The block works on one word at a time. A word stored at position j holds
//   req_stall high through one insert probe of the hashed lookup table, per
//   earlier position a difference, a lookup probe and a write, and a closing
//   state; a negative difference skips its probe, and a hash collision adds
//   an extra probe. A last word adds a flush of the used lookup slots, one per
//   distinct value, and the load of the result register.
// Reset:
//   Synchronous reset clears the counters, then a clearing pass over the
//   2**($clog2(MAX_ITEMS)+1) lookup slots, one slot at a time, holds
//   req_stall high. A stalled result stays in its register while the next
//   sequence is taken; a second result waits until the first is taken.
// ----------------------------------------------------------------------------
module longest_fibonacci_subsequence #(
   parameter int MAX_ITEMS = lfs_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lfs_pkg::VALUE_W-1:0]  req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lfs_pkg::LEN_W-1:0]    rsp_best_length,
   output logic                         rsp_overflow
);

   lfs_pkg::cmd_type cmd;
   lfs_pkg::sts_type sts;

   lfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfs_dpath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_best_length (rsp_best_length),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

/* sv/lfs_checker.sv */
// ----------------------------------------------------------------------------
// lfs_checker: port-level checks for the Fibonacci-like subsequence block
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module lfs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [lfs_pkg::LEN_W-1:0] rsp_best_length,
   input logic                      rsp_overflow
);

   // reset starts the clearing pass with no result pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("request side open or result pending after reset");

   // a taken word keeps the block busy for at least the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // lengths of one or two never show
   a_no_short_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_best_length != 8'd1 && rsp_best_length != 8'd2)
      else $error("short length reported");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_length)
                                 && $stable(rsp_overflow))
      else $error("stalled result word changed");

endmodule

bind longest_fibonacci_subsequence lfs_checker u_lfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_best_length (rsp_best_length),
   .rsp_overflow    (rsp_overflow)
);

/* tb/sv/longest_fibonacci_subsequence_tb.sv */
// ----------------------------------------------------------------------------
// longest_fibonacci_subsequence_tb: self-checking bench for the subsequence block
// Streams value words grouped into sequences: a short directed set, then
// mostly increasing sequences with Fibonacci-like steps and random content,
// plus noise and broken runs. A scoreboard tracks the stored values and the
// pair-length table to predict each result word, and checks every word that
// leaves the block. Both channels idle at random, and the receiver holds off
// once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module longest_fibonacci_subsequence_tb;

   localparam int          MAX_SEQ       = lfs_pkg::MAX_ITEMS_DEFAULT;
   localparam int          VW            = lfs_pkg::VALUE_W;
   localparam int          LW            = lfs_pkg::LEN_W;
   localparam int          WORD_TARGET   = 950;
   localparam int          HOLD_CYCLES   = 3000;
   localparam int          STALL_LIMIT   = 20000;
   localparam int          DRAIN_CYCLES  = 700;
   localparam longint      VALUE_MAX     = 64'h7FFF_FFFF;

   typedef enum int {SEQ_CHAIN, SEQ_NOISE, SEQ_BROKEN} seq_kind_type;

   typedef struct {
      logic [LW-1:0] best_length;
      logic          overflow;
   } fib_result_type;

   // Track value store and pair lengths; queue one result per closing word.
   class fib_board_type;
      logic [VW-1:0]      value_store [MAX_SEQ];
      logic [LW-1:0]      pair_len [MAX_SEQ*MAX_SEQ];
      int                 stored = 0;
      int                 best = 0;
      logic               dropped = 1'b0;
      fib_result_type     expected_lengths [$];
      int                 errors = 0;

      function void note_word(logic [VW-1:0] value, logic last);
         fib_result_type res;
         longint      cur;
         longint      diff;
         longint      probe;
         int          j;
         int          i;
         int          k;
         int          p;
         int          len;
         if (stored < MAX_SEQ) begin
            j = stored;
            value_store[j] = value;
            cur = value;
            for (i = j - 1; i >= 0; i--) begin
               probe = value_store[i];
               diff = cur - probe;
               // find the highest position holding the difference
               k = -1;
               if (diff >= 0) begin
                  for (p = j; p >= 0 && k < 0; p--) begin
                     probe = value_store[p];
                     if (probe == diff) k = p;
                  end
               end
               if (k >= 0 && k < i) begin
                  len = pair_len[k*MAX_SEQ + i] + 1;
                  if (len > lfs_pkg::LEN_MAX) len = lfs_pkg::LEN_MAX;
               end else begin
                  len = lfs_pkg::LEN_BASE;
               end
               pair_len[i*MAX_SEQ + j] = LW'(len);
               if (len > best) best = len;
            end
            stored = j + 1;
         end else begin
            dropped = 1'b1;
         end
         if (last) begin
            res.best_length = (best > 2) ? LW'(best) : '0;
            res.overflow = dropped;
            expected_lengths.push_back(res);
            stored = 0;
            best = 0;
            dropped = 1'b0;
         end
      endfunction

      function void check_result(logic [LW-1:0] best_length, logic overflow);
         fib_result_type res;
         if (expected_lengths.size() == 0) begin
            $error("result word with nothing expected: best_length %0d overflow %0d",
                   best_length, overflow);
            errors++;
         end else begin
            res = expected_lengths.pop_front();
            if (best_length !== res.best_length) begin
               $error("best_length: expected %0d, actual %0d", res.best_length, best_length);
               errors++;
            end
            if (overflow !== res.overflow) begin
               $error("overflow: expected %0d, actual %0d", res.overflow, overflow);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_lengths.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [VW-1:0]      req_value;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [LW-1:0]      rsp_best_length;
   logic               rsp_overflow;

   fib_board_type   board;
   int              phase = 0;
   int              send_idle_pct = 26;
   int              rsp_idle_pct = 71;
   int              words_sent = 0;

   longest_fibonacci_subsequence u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_best_length (rsp_best_length),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one word after a random gap; hold it until the block takes it.
   task automatic send_word(input logic [VW-1:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(value, last);
      words_sent++;
   endtask

   // Build and send one sequence of the given length and flavor.
   task automatic send_sequence(input int len, input seq_kind_type kind);
      longint vals [256];
      longint v;
      int     n;
      int     r;
      for (n = 0; n < len; n++) begin
         if (kind == SEQ_NOISE) begin
            if ($urandom_range(0, 3) == 0) v = $urandom & VALUE_MAX;
            else v = $urandom_range(0, 40);
         end else if (n == 0) begin
            r = $urandom_range(0, 9);
            if (r < 8) v = $urandom_range(1, 20);
            else if (r == 8) v = $urandom_range(32'h7FFF_FFFF, 1);
            else v = VALUE_MAX - $urandom_range(0, 50);
         end else begin
            r = $urandom_range(0, 99);
            if (n == 1) v = vals[0] + $urandom_range(1, 20);
            else if (r < 45) v = vals[n-1] + vals[n-2];
            else if (r < 65) v = vals[n-1] + vals[$urandom_range(0, n - 2)];
            else v = vals[n-1] + $urandom_range(1, 50);
            // past the top of the range: step by one or fall back to noise
            if (v > VALUE_MAX) begin
               if (vals[n-1] < VALUE_MAX) v = vals[n-1] + 1;
               else v = $urandom & VALUE_MAX;
            end
            // break the order now and then
            if (kind == SEQ_BROKEN && $urandom_range(0, 99) < 15) begin
               r = $urandom_range(0, 3);
               if (r == 0) v = vals[$urandom_range(0, n - 1)];
               else if (r == 1) v = 0;
               else if (r == 2) v = $urandom & VALUE_MAX;
               else if (vals[n-1] > 5) v = vals[n-1] - $urandom_range(1, 5);
            end
         end
         vals[n] = v;
         send_word(v[VW-1:0], n == len - 1);
      end
   endtask

   // Check result words; drive the result-side stall with one long hold-off.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_best_length, rsp_overflow);
         if (phase == 2 && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   // Watchdog: end the run when no word moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int           seq_no;
      int           len;
      int           r;
      seq_kind_type kind;
      board = new;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      req_last  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single word closes the sequence
      send_word(31'd5, 1'b1);
      // shortest run of three
      send_word(31'd1, 1'b0);
      send_word(31'd2, 1'b0);
      send_word(31'd3, 1'b1);
      // best of two reads as zero
      send_word(31'd1, 1'b0);
      send_word(31'd2, 1'b1);
      // zero values match a stored zero
      send_word(31'd0, 1'b0);
      send_word(31'd0, 1'b0);
      send_word(31'd0, 1'b1);
      // decreasing values around the top of the range
      send_word(31'h7FFF_FFFF, 1'b0);
      send_word(31'h7FFF_FFFE, 1'b0);
      send_word(31'd1, 1'b1);
      // duplicates pick the highest position
      send_word(31'd2, 1'b0);
      send_word(31'd2, 1'b0);
      send_word(31'd4, 1'b0);
      send_word(31'd6, 1'b1);
      // plain Fibonacci run
      send_word(31'd1, 1'b0);
      send_word(31'd2, 1'b0);
      send_word(31'd3, 1'b0);
      send_word(31'd5, 1'b0);
      send_word(31'd8, 1'b1);
      // sum lands exactly on the largest value
      send_word(31'h3FFF_FFFF, 1'b0);
      send_word(31'h4000_0000, 1'b0);
      send_word(31'h7FFF_FFFF, 1'b1);

      // random sequences, three idling phases
      seq_no = 0;
      while (words_sent < WORD_TARGET) begin
         if (words_sent < WORD_TARGET / 3) begin
            phase = 0;
            send_idle_pct = 26;
            rsp_idle_pct = 71;
         end else if (words_sent < 2 * WORD_TARGET / 3) begin
            phase = 1;
            send_idle_pct = 71;
            rsp_idle_pct = 26;
         end else begin
            phase = 2;
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // a few long runs fill the store, the first one past capacity
         if (seq_no == 2) len = MAX_SEQ + 3;
         else if (seq_no % 40 == 25) len = $urandom_range(60, MAX_SEQ + 7);
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 40);
         else len = $urandom_range(1, 16);
         r = $urandom_range(0, 9);
         if (r < 8) kind = SEQ_CHAIN;
         else if (r == 8) kind = SEQ_NOISE;
         else kind = SEQ_BROKEN;
         send_sequence(len, kind);
         seq_no++;
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the block settle
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* longest_fibonacci_subsequence.f */
sv/lfs_pkg.sv
sv/lfs_ctrl.sv
sv/lfs_dpath.sv
sv/longest_fibonacci_subsequence.sv
sv/lfs_checker.sv
tb/sv/longest_fibonacci_subsequence_tb.sv
